[design/v2c_pkg.sv]
// Shared types and constants for the valid-mode 2D correlation core.
// No dependencies; used by v2c_sum_pipe and valid_2d_correlation_core.
package v2c_pkg;

    // Fixed widths of the configuration registers and of the result.
    localparam int IMG_CFG_W  = 11;
    localparam int KER_CFG_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SUM_W      = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KER_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KER_COLS = 2'd3;

    // Input command codes.
    localparam logic CMD_KERNEL = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    // End-of-row and end-of-frame marks that travel with a result.
    typedef struct packed {
        logic row_last;
        logic frame_last;
    } t_marks;

endpackage

[design/v2c_sum_pipe.sv]
// Multiply array and registered adder tree of the correlation core.
// Depends on v2c_pkg for the result width and the mark struct.
module v2c_sum_pipe #(
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                                     i_clk,
    input  logic                                                     i_rst_n,
    input  logic                                                     i_valid,
    output logic                                                     o_stall,
    input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0]   i_win,
    input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0]   i_coef,
    input  v2c_pkg::t_marks                                          i_marks,
    output logic                                                     o_valid,
    input  logic                                                     i_stall,
    output logic signed [v2c_pkg::SUM_W-1:0]                         o_sum,
    output v2c_pkg::t_marks                                          o_marks
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL) + 1;

    logic signed [PROD_W-1:0] r_prod [MAX_KERNEL][MAX_KERNEL];
    logic signed [ACC_W-1:0]  r_row_sum [MAX_KERNEL];
    logic signed [ACC_W-1:0]  n_row_sum [MAX_KERNEL];
    logic signed [ACC_W-1:0]  n_total;
    v2c_pkg::t_marks          r_a_marks;
    v2c_pkg::t_marks          r_b_marks;
    logic                     r_a_valid;
    logic                     r_b_valid;
    logic                     r_o_valid;
    logic                     w_en_a;
    logic                     w_en_b;
    logic                     w_en_o;

    assign w_en_o  = !r_o_valid || !i_stall;
    assign w_en_b  = !r_b_valid || w_en_o;
    assign w_en_a  = !r_a_valid || w_en_b;
    assign o_stall = !w_en_a;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_en_a) r_a_valid <= i_valid;
            if (w_en_b) r_b_valid <= r_a_valid;
            if (w_en_o) r_o_valid <= r_b_valid;
        end
    end

    // One product per window position, registered before any addition.
    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_marks <= i_marks;
            for (int a = 0; a < MAX_KERNEL; a++) begin
                for (int b = 0; b < MAX_KERNEL; b++) begin
                    r_prod[a][b] <= $signed(i_win[a][b]) * $signed(i_coef[a][b]);
                end
            end
        end
    end

    // First tree level: one sum per window row.
    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            n_row_sum[a] = '0;
            for (int b = 0; b < MAX_KERNEL; b++) begin
                n_row_sum[a] = n_row_sum[a] + ACC_W'(r_prod[a][b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_marks <= r_a_marks;
            for (int a = 0; a < MAX_KERNEL; a++) begin
                r_row_sum[a] <= n_row_sum[a];
            end
        end
    end

    // Second tree level: the row sums into the final result.
    always_comb begin
        n_total = '0;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            n_total = n_total + r_row_sum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o) begin
            o_sum   <= v2c_pkg::SUM_W'(n_total);
            o_marks <= r_b_marks;
        end
    end

endmodule

[design/valid_2d_correlation_core.sv]
// Valid-mode 2D correlation core: an accepted pixel passes stage 1, stage 2 and the sum pipe
// before its result reaches the output register; one transaction is accepted every cycle
// while o_stall is low.
// Reset (synchronous, active low) clears the raster and coefficient positions and sets all four
// size registers to 1; the line memory and the coefficients are undefined until written.
module valid_2d_correlation_core #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 1024,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [v2c_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [v2c_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]         i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [v2c_pkg::SUM_W-1:0]      o_sum,
    output logic                                  o_row_last,
    output logic                                  o_frame_last
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LIDX_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int KW     = v2c_pkg::KER_CFG_W;
    localparam int IW     = v2c_pkg::IMG_CFG_W;

    typedef logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] t_word;
    typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] t_grid;

    // ------------------------------------------------------------------
    // Configuration registers and their clamped working values.
    // ------------------------------------------------------------------
    logic [IW-1:0] r_img_rows;
    logic [IW-1:0] r_img_cols;
    logic [KW-1:0] r_ker_rows;
    logic [KW-1:0] r_ker_cols;
    logic [IW-1:0] w_rows;
    logic [IW-1:0] w_cols;
    logic [KW-1:0] w_kr;
    logic [KW-1:0] w_kc;

    // Out-of-range sizes saturate: zero acts as one, too large acts as the maximum.
    always_comb begin
        if (r_img_rows == '0)                   w_rows = IW'(1);
        else if (int'(r_img_rows) > MAX_ROWS)   w_rows = IW'(MAX_ROWS);
        else                                    w_rows = r_img_rows;
        if (r_img_cols == '0)                   w_cols = IW'(1);
        else if (int'(r_img_cols) > MAX_COLS)   w_cols = IW'(MAX_COLS);
        else                                    w_cols = r_img_cols;
        if (r_ker_rows == '0)                   w_kr = KW'(1);
        else if (int'(r_ker_rows) > MAX_KERNEL) w_kr = KW'(MAX_KERNEL);
        else                                    w_kr = r_ker_rows;
        if (r_ker_cols == '0)                   w_kc = KW'(1);
        else if (int'(r_ker_cols) > MAX_KERNEL) w_kc = KW'(MAX_KERNEL);
        else                                    w_kc = r_ker_cols;
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Stage 1 holds the line memory read data, stage 2
    // holds the updated window; the sum pipe owns everything after that.
    // A kernel transaction rides the same pipeline so that it updates the
    // coefficients only after every earlier pixel has taken its products.
    // ------------------------------------------------------------------
    logic w_pipe_stall;
    logic w_s2_en;
    logic w_s1_en;
    logic w_accept;
    logic w_s1_fire;
    logic w_s2_fire;
    logic w_mem_we;

    logic                   r_s1_valid;
    logic                   r_s1_pix;
    logic [SAMPLE_BITS-1:0] r_s1_value;
    logic [COL_W-1:0]       r_s1_col;
    logic [LIDX_W-1:0]      r_s1_lidx;
    logic                   r_s1_emit;
    v2c_pkg::t_marks        r_s1_marks;
    logic [LIDX_W-1:0]      r_s1_ka;
    logic [LIDX_W-1:0]      r_s1_kb;

    logic                   r_s2_valid;
    logic                   r_s2_pix;
    logic [SAMPLE_BITS-1:0] r_s2_value;
    v2c_pkg::t_marks        r_s2_marks;
    logic [LIDX_W-1:0]      r_s2_ka;
    logic [LIDX_W-1:0]      r_s2_kb;

    // A kernel transaction in stage 2 always leaves; a pixel waits for the sum pipe.
    assign w_s2_en   = !r_s2_valid || !r_s2_pix || !w_pipe_stall;
    assign w_s1_en   = !r_s1_valid || w_s2_en;
    assign w_accept  = i_valid && w_s1_en;
    assign o_stall   = !w_s1_en;
    assign w_s1_fire = r_s1_valid && w_s2_en;
    assign w_s2_fire = r_s2_valid && w_s2_en;
    assign w_mem_we  = w_s1_fire && r_s1_pix;

    // ------------------------------------------------------------------
    // Raster position, line slot and coefficient position.
    // The line slot is the row position modulo the kernel limit, kept as
    // its own wrapping counter.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  r_row_pos;
    logic [COL_W-1:0]  r_col_pos;
    logic [LIDX_W-1:0] r_lidx;
    logic [KW-1:0]     r_coef_p;
    logic [KW-1:0]     r_coef_q;
    logic              w_col_last;
    logic              w_row_last;
    logic              w_emit;
    logic              w_coef_q_last;
    logic              w_coef_p_last;

    assign w_col_last    = (int'(r_col_pos) + 1 == int'(w_cols));
    assign w_row_last    = (int'(r_row_pos) + 1 == int'(w_rows));
    assign w_emit        = (int'(r_row_pos) + 1 >= int'(w_kr)) &&
                           (int'(r_col_pos) + 1 >= int'(w_kc));
    assign w_coef_q_last = (int'(r_coef_q) + 1 >= int'(w_kc));
    assign w_coef_p_last = (int'(r_coef_p) + 1 >= int'(w_kr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_rows <= IW'(1);
            r_img_cols <= IW'(1);
            r_ker_rows <= KW'(1);
            r_ker_cols <= KW'(1);
            r_row_pos  <= '0;
            r_col_pos  <= '0;
            r_lidx     <= '0;
            r_coef_p   <= '0;
            r_coef_q   <= '0;
        end else if (i_cfg_we) begin
            // A new image size restarts the frame; a new kernel size restarts the load.
            unique case (i_cfg_index)
                v2c_pkg::CFG_IMG_ROWS: begin
                    r_img_rows <= i_cfg_data;
                    r_row_pos  <= '0;
                    r_col_pos  <= '0;
                    r_lidx     <= '0;
                end
                v2c_pkg::CFG_IMG_COLS: begin
                    r_img_cols <= i_cfg_data;
                    r_row_pos  <= '0;
                    r_col_pos  <= '0;
                    r_lidx     <= '0;
                end
                v2c_pkg::CFG_KER_ROWS: begin
                    r_ker_rows <= i_cfg_data[KW-1:0];
                    r_coef_p   <= '0;
                    r_coef_q   <= '0;
                end
                v2c_pkg::CFG_KER_COLS: begin
                    r_ker_cols <= i_cfg_data[KW-1:0];
                    r_coef_p   <= '0;
                    r_coef_q   <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            if (i_cmd == v2c_pkg::CMD_PIXEL) begin
                if (w_col_last) begin
                    r_col_pos <= '0;
                    if (w_row_last) begin
                        r_row_pos <= '0;
                        r_lidx    <= '0;
                    end else begin
                        r_row_pos <= r_row_pos + 1'b1;
                        r_lidx    <= (r_lidx == LIDX_W'(MAX_KERNEL - 1)) ? '0
                                                                         : r_lidx + 1'b1;
                    end
                end else begin
                    r_col_pos <= r_col_pos + 1'b1;
                end
            end else begin
                if (w_coef_q_last) begin
                    r_coef_q <= '0;
                    r_coef_p <= w_coef_p_last ? '0 : r_coef_p + 1'b1;
                end else begin
                    r_coef_q <= r_coef_q + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one word per image column holds that column's sample
    // from every line slot. Each pixel reads its column, replaces its own
    // slot and writes the word back when it leaves stage 1. With a one-column
    // image the next pixel reads the same word in the cycle of that write,
    // so the written word is forwarded to it.
    // ------------------------------------------------------------------
    t_word r_line_mem [MAX_COLS];
    t_word r_rdata;
    t_word r_fwd_word;
    logic  r_fwd;
    t_word w_word_in;
    t_word w_word_new;
    t_word w_age_col;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= r_line_mem[r_col_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_line_mem[r_s1_col] <= w_word_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (w_accept) begin
            r_fwd <= w_mem_we && (r_s1_col == r_col_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fwd_word <= w_word_new;
        end
    end

    always_comb begin
        w_word_in             = r_fwd ? r_fwd_word : r_rdata;
        w_word_new            = w_word_in;
        w_word_new[r_s1_lidx] = r_s1_value;
    end

    // Reorder the column by age: entry 0 is the current row, entry 1 the row above, and so on.
    always_comb begin
        int slot;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            slot = int'(r_s1_lidx) - a;
            if (slot < 0) slot = slot + MAX_KERNEL;
            w_age_col[a] = w_word_new[slot[LIDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_en) r_s1_valid <= w_accept;
            // A pixel without a full window ends its work in stage 1.
            if (w_s2_en) r_s2_valid <= w_s1_fire && (!r_s1_pix || r_s1_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix              <= (i_cmd == v2c_pkg::CMD_PIXEL);
            r_s1_value            <= i_value;
            r_s1_col              <= r_col_pos;
            r_s1_lidx             <= r_lidx;
            r_s1_emit             <= w_emit;
            r_s1_marks.row_last   <= w_col_last;
            r_s1_marks.frame_last <= w_col_last && w_row_last;
            // Coefficients are stored by age, so row p of the kernel lands at kr-1-p.
            r_s1_ka               <= LIDX_W'(w_kr - KW'(1) - r_coef_p);
            r_s1_kb               <= LIDX_W'(w_kc - KW'(1) - r_coef_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_s2_pix   <= r_s1_pix;
            r_s2_value <= r_s1_value;
            r_s2_marks <= r_s1_marks;
            r_s2_ka    <= r_s1_ka;
            r_s2_kb    <= r_s1_kb;
        end
    end

    // ------------------------------------------------------------------
    // Window registers indexed by row age and column age; every pixel
    // shifts in one new column. The kernel registers use the same indexing.
    // ------------------------------------------------------------------
    t_grid r_win;
    t_grid r_kern;
    t_grid w_coef;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            for (int a = 0; a < MAX_KERNEL; a++) begin
                for (int b = MAX_KERNEL - 1; b > 0; b--) begin
                    r_win[a][b] <= r_win[a][b-1];
                end
                r_win[a][0] <= w_age_col[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire && !r_s2_pix) begin
            r_kern[r_s2_ka][r_s2_kb] <= r_s2_value;
        end
    end

    // Positions outside the kernel in use contribute nothing.
    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            for (int b = 0; b < MAX_KERNEL; b++) begin
                w_coef[a][b] = (a < int'(w_kr) && b < int'(w_kc)) ? r_kern[a][b] : '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Products, adder tree and output register.
    // ------------------------------------------------------------------
    v2c_pkg::t_marks w_out_marks;

    v2c_sum_pipe #(
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sum_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid && r_s2_pix),
        .o_stall (w_pipe_stall),
        .i_win   (r_win),
        .i_coef  (w_coef),
        .i_marks (r_s2_marks),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_sum   (o_sum),
        .o_marks (w_out_marks)
    );

    assign o_row_last   = w_out_marks.row_last;
    assign o_frame_last = w_out_marks.frame_last;

endmodule
